@@ hw/rtl/mvm_pkg.sv @@
package mvm_pkg;

	localparam int DIM_W           = 5;
	localparam int DIM_CMP_W       = 7;
	localparam int ROW_IDX_W       = 4;
	localparam int COL_IDX_W       = 4;
	localparam int VALUE_IN_W      = 16;
	localparam int DOT_W           = 40;
	localparam int STATUS_W        = 2;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;

	localparam int DEF_MAX_ROWS    = 16;
	localparam int DEF_MAX_COLS    = 16;
	localparam int DEF_VALUE_WIDTH = 16;

	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_VECTOR = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
	} mac_ctl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] x,
			input logic [DIM_CMP_W-1:0] top);
		logic [DIM_W-1:0] r;
		if (x == '0) begin
			r = DIM_W'(1);
		end else if (DIM_CMP_W'(x) > top) begin
			r = top[DIM_W-1:0];
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/mvm_store.sv @@
module mvm_store
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int MAT_DEPTH  = MAX_ROWS * MAX_COLS,
	localparam int MA_W       = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1,
	localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                          clk,
	input  logic                          mat_we,
	input  logic [MA_W-1:0]               mat_waddr,
	input  logic signed [VALUE_WIDTH-1:0] mat_wdata,
	input  logic [MA_W-1:0]               mat_raddr,
	output logic signed [VALUE_WIDTH-1:0] mat_rdata,
	input  logic                          vec_we,
	input  logic [COL_W-1:0]              vec_waddr,
	input  logic signed [VALUE_WIDTH-1:0] vec_wdata,
	input  logic [COL_W-1:0]              vec_raddr,
	output logic signed [VALUE_WIDTH-1:0] vec_rdata
);

	logic signed [VALUE_WIDTH-1:0] mat_mem [MAT_DEPTH];
	logic signed [VALUE_WIDTH-1:0] vec_mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		mat_rdata <= mat_mem[mat_raddr];
	end

	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[vec_waddr] <= vec_wdata;
		end
		vec_rdata <= vec_mem[vec_raddr];
	end

endmodule

@@ hw/rtl/mvm_mac.sv @@
module mvm_mac
	import mvm_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [VALUE_WIDTH-1:0] b,
	output logic                          busy,
	output logic signed [DOT_W-1:0]       acc
);

	localparam int PW = 2 * VALUE_WIDTH;
	localparam int SW = ((PW > DOT_W) ? PW : DOT_W) + 1;
	localparam logic signed [SW-1:0] SAT_HI =
		$signed({{(SW-DOT_W+1){1'b0}}, {(DOT_W-1){1'b1}}});
	localparam logic signed [SW-1:0] SAT_LO =
		$signed({{(SW-DOT_W+1){1'b1}}, {(DOT_W-1){1'b0}}});

	mac_ctl_t                 ctl_s2;
	logic signed [PW-1:0]     prod_s2;
	logic signed [DOT_W-1:0]  acc_q;
	logic signed [DOT_W-1:0]  base;
	logic signed [SW-1:0]     sum;
	logic signed [DOT_W-1:0]  sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prod_s2 <= PW'(a) * PW'(b);
		end
		if (ctl_s2.valid) begin
			acc_q <= sat;
		end
	end

	always_comb begin
		base = ctl_s2.first ? '0 : acc_q;
		sum  = SW'(base) + SW'(prod_s2);
		if (sum > SAT_HI) begin
			sat = SAT_HI[DOT_W-1:0];
		end else if (sum < SAT_LO) begin
			sat = SAT_LO[DOT_W-1:0];
		end else begin
			sat = sum[DOT_W-1:0];
		end
	end

	assign busy = ctl_s2.valid;
	assign acc  = acc_q;

endmodule

@@ hw/rtl/matrix_vector_multiply.sv @@
// Matrix-vector multiplier, y = M*x, signed Q3.12 in, saturating Q15.24 out in 40 bits.
// Matrix entry writes each return one status transaction once the output register is free;
// vector elements return nothing until the element marked last. A good run then reads one
// matrix word per cycle for each row in use into one multiply-accumulate unit, then drains
// the pipeline and waits for a free output register before each row result, and a mismatched
// run returns its single transaction as soon as an entry write would. One input transaction
// waits in a holding register until the block takes it, and the input stalls while that
// register is full, so a new transaction is accepted only after the held one has been taken.
// Memories need no clearing after reset; matrix entries read must have been written.
module matrix_vector_multiply
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_AW-1:0]            paddr,
	input  logic [APB_DW-1:0]            pwdata,
	output logic [APB_DW-1:0]            prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [ROW_IDX_W-1:0]         row_sel,
	input  logic [COL_IDX_W-1:0]         col_sel,
	input  logic signed [VALUE_IN_W-1:0] value,
	input  logic                         last_elem,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ROW_IDX_W-1:0]         row_index,
	output logic signed [DOT_W-1:0]      dot_product,
	output logic [STATUS_W-1:0]          status,
	output logic                         last_result
);

	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MA_W      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W     = $clog2(MAX_COLS + 1);
	localparam logic [DIM_CMP_W-1:0] ROWS_TOP = DIM_CMP_W'(MAX_ROWS);
	localparam logic [DIM_CMP_W-1:0] COLS_TOP = DIM_CMP_W'(MAX_COLS);

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic             cfg_wr;

	logic                          hold_q;
	logic                          h_action_q;
	logic [ROW_IDX_W-1:0]          h_row_q;
	logic [COL_IDX_W-1:0]          h_col_q;
	logic signed [VALUE_WIDTH-1:0] h_value_q;
	logic                          h_last_q;
	logic signed [VALUE_WIDTH-1:0] value_ext;
	logic                          in_acc;
	logic                          consume;

	state_t           state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [CNT_W-1:0] count_q, count_d, cnt_next;
	logic             ovf_q, ovf_d;

	mac_ctl_t ctl_d, ctl_s1;

	logic                          mat_we, vec_we;
	logic [MA_W-1:0]               mat_waddr, mat_raddr;
	logic [COL_W-1:0]              vec_waddr;
	logic signed [VALUE_WIDTH-1:0] mat_rdata, vec_rdata;
	logic                          mac_busy;
	logic signed [DOT_W-1:0]       acc;

	logic [DIM_CMP_W-1:0] rows_ext, cols_ext;
	logic                 in_range, can_store, mismatch, out_free, row_last, col_last;

	logic                          out_valid_q, out_valid_d, load_out;
	logic [ROW_IDX_W-1:0]          o_row_q, o_row_d;
	logic signed [DOT_W-1:0]       o_dot_q, o_dot_d;
	logic [STATUS_W-1:0]           o_status_q, o_status_d;
	logic                          o_last_q, o_last_d;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= clamp_dim(DIM_RESET, ROWS_TOP);
			cols_q <= clamp_dim(DIM_RESET, COLS_TOP);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ROWS: rows_q <= clamp_dim(pwdata[DIM_W-1:0], ROWS_TOP);
				REG_COLS: cols_q <= clamp_dim(pwdata[DIM_W-1:0], COLS_TOP);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROWS: prdata = APB_DW'(rows_q);
			REG_COLS: prdata = APB_DW'(cols_q);
			default:  prdata = '0;
		endcase
	end

	// input holding register
	generate
		if (VALUE_WIDTH <= VALUE_IN_W) begin : g_narrow
			assign value_ext = value[VALUE_WIDTH-1:0];
		end else begin : g_wide
			assign value_ext = $signed({{(VALUE_WIDTH-VALUE_IN_W){1'b0}}, value});
		end
	endgenerate

	assign in_stall = hold_q;
	assign in_acc   = in_valid && !hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_acc) begin
			hold_q <= 1'b1;
		end else if (consume) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			h_action_q <= action;
			h_row_q    <= row_sel;
			h_col_q    <= col_sel;
			h_value_q  <= value_ext;
			h_last_q   <= last_elem;
		end
	end

	// sequencer
	assign rows_ext  = DIM_CMP_W'(rows_q);
	assign cols_ext  = DIM_CMP_W'(cols_q);
	assign in_range  = (DIM_CMP_W'(h_row_q) < rows_ext) && (DIM_CMP_W'(h_col_q) < cols_ext);
	assign can_store = DIM_CMP_W'(count_q) < cols_ext;
	assign cnt_next  = can_store ? count_q + CNT_W'(1) : count_q;
	assign mismatch  = ovf_q || !can_store || (DIM_CMP_W'(cnt_next) != cols_ext);
	assign out_free  = !out_valid_q || !out_stall;
	assign row_last  = (DIM_CMP_W'(row_q) + DIM_CMP_W'(1)) == rows_ext;
	assign col_last  = (DIM_CMP_W'(col_q) + DIM_CMP_W'(1)) == cols_ext;

	assign mat_waddr = MA_W'(MA_W'(h_row_q) * MA_W'(MAX_COLS) + MA_W'(h_col_q));
	assign mat_raddr = MA_W'(MA_W'(row_q) * MA_W'(MAX_COLS) + MA_W'(col_q));
	assign vec_waddr = count_q[COL_W-1:0];

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		count_d     = count_q;
		ovf_d       = ovf_q;
		consume     = 1'b0;
		mat_we      = 1'b0;
		vec_we      = 1'b0;
		ctl_d       = '0;
		load_out    = 1'b0;
		o_row_d     = o_row_q;
		o_dot_d     = o_dot_q;
		o_status_d  = o_status_q;
		o_last_d    = o_last_q;
		case (state_q)
			S_IDLE: begin
				if (hold_q) begin
					if (h_action_q == ACT_WRITE) begin
						if (out_free) begin
							consume    = 1'b1;
							mat_we     = in_range;
							load_out   = 1'b1;
							o_row_d    = h_row_q;
							o_dot_d    = '0;
							o_status_d = in_range ? ST_OK : ST_RANGE;
							o_last_d   = 1'b0;
						end
					end else if (!(h_last_q && mismatch) || out_free) begin
						consume = 1'b1;
						vec_we  = can_store;
						count_d = cnt_next;
						ovf_d   = ovf_q || !can_store;
						if (h_last_q) begin
							count_d = '0;
							ovf_d   = 1'b0;
							if (mismatch) begin
								load_out   = 1'b1;
								o_row_d    = '0;
								o_dot_d    = '0;
								o_status_d = ST_MISMATCH;
								o_last_d   = 1'b1;
							end else begin
								state_d = S_READ;
								row_d   = '0;
								col_d   = '0;
							end
						end
					end
				end
			end
			S_READ: begin
				ctl_d.valid = 1'b1;
				ctl_d.first = (col_q == '0);
				if (col_last) begin
					col_d   = '0;
					state_d = S_DRAIN;
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			S_DRAIN: begin
				if (!ctl_s1.valid && !mac_busy && out_free) begin
					load_out   = 1'b1;
					o_row_d    = ROW_IDX_W'(row_q);
					o_dot_d    = acc;
					o_status_d = ST_OK;
					o_last_d   = row_last;
					if (row_last) begin
						state_d = S_IDLE;
					end else begin
						row_d   = row_q + ROW_W'(1);
						state_d = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = load_out || (out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
			ctl_s1      <= ctl_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_row_q    <= o_row_d;
			o_dot_q    <= o_dot_d;
			o_status_q <= o_status_d;
			o_last_q   <= o_last_d;
		end
	end

	mvm_store #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk       (clk),
		.mat_we    (mat_we),
		.mat_waddr (mat_waddr),
		.mat_wdata (h_value_q),
		.mat_raddr (mat_raddr),
		.mat_rdata (mat_rdata),
		.vec_we    (vec_we),
		.vec_waddr (vec_waddr),
		.vec_wdata (h_value_q),
		.vec_raddr (col_q),
		.vec_rdata (vec_rdata)
	);

	mvm_mac #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.a      (mat_rdata),
		.b      (vec_rdata),
		.busy   (mac_busy),
		.acc    (acc)
	);

	assign out_valid   = out_valid_q;
	assign row_index   = o_row_q;
	assign dot_product = o_dot_q;
	assign status      = o_status_q;
	assign last_result = o_last_q;

endmodule

@@ hw/rtl/mvm_checker.sv @@
module mvm_checker
	import mvm_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [ROW_IDX_W-1:0]    row_index,
	input logic signed [DOT_W-1:0] dot_product,
	input logic [STATUS_W-1:0]     status,
	input logic                    last_result
);

	// stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(dot_product) && $stable(row_index))
		else $error("result payload changed while stalled");

	// a mismatch closes the run on its own
	a_mismatch_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MISMATCH |->
			last_result && row_index == '0 && dot_product == '0)
		else $error("malformed mismatch result");

	// out-of-range entry write status never carries a sum or ends a run
	a_range_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> !last_result && dot_product == '0)
		else $error("malformed out-of-range result");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.row_index   (row_index),
	.dot_product (dot_product),
	.status      (status),
	.last_result (last_result)
);

@@ sim/matrix_vector_multiply_tb.sv @@
module matrix_vector_multiply_tb;
	import mvm_pkg::*;

	typedef struct packed {
		logic                         act;
		logic [ROW_IDX_W-1:0]         row;
		logic [COL_IDX_W-1:0]         col;
		logic signed [VALUE_IN_W-1:0] val;
		logic                         last;
	} mvm_item_t;

	typedef struct packed {
		logic [ROW_IDX_W-1:0]    row;
		logic signed [DOT_W-1:0] dot;
		logic [STATUS_W-1:0]     st;
		logic                    last;
	} mvm_res_t;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic       reg_idx;
		logic [4:0] raw;
		mvm_item_t  it;
		logic       typed;
		mvm_res_t   want;
	} step_t;

	localparam longint DOT_HI = (longint'(1) <<< (DOT_W - 1)) - 1;
	localparam longint DOT_LO = -DOT_HI - 1;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [APB_AW-1:0]            paddr;
	logic [APB_DW-1:0]            pwdata;
	logic [APB_DW-1:0]            prdata;
	logic                         pready;
	logic                         in_valid;
	logic                         in_stall;
	logic                         action;
	logic [ROW_IDX_W-1:0]         row_sel;
	logic [COL_IDX_W-1:0]         col_sel;
	logic signed [VALUE_IN_W-1:0] value;
	logic                         last_elem;
	logic                         out_valid;
	logic                         out_stall;
	logic [ROW_IDX_W-1:0]         row_index;
	logic signed [DOT_W-1:0]      dot_product;
	logic [STATUS_W-1:0]          status;
	logic                         last_result;

	matrix_vector_multiply uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.value      (value),
		.last_elem  (last_elem),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.dot_product(dot_product),
		.status     (status),
		.last_result(last_result)
	);

	// predictor state
	logic signed [VALUE_IN_W-1:0] coef [DEF_MAX_ROWS][DEF_MAX_COLS];
	bit                           coef_set [DEF_MAX_ROWS][DEF_MAX_COLS];
	logic signed [VALUE_IN_W-1:0] vec_buf [DEF_MAX_COLS];
	int                           vec_cnt = 0;
	bit                           vec_over = 0;
	int                           n_rows = DEF_MAX_ROWS;
	int                           n_cols = DEF_MAX_COLS;

	mvm_res_t  step_out[$];
	mvm_res_t  row_results_q[$];
	step_t     directed_tab[$];
	int        bad_count = 0;
	int        sent = 0;
	int        burst_left = 0;
	bit        hold_request = 0;

	function automatic mvm_res_t make_res(input logic [ROW_IDX_W-1:0] row,
			input logic signed [DOT_W-1:0] dot, input logic [STATUS_W-1:0] st,
			input logic last);
		mvm_res_t r;
		r.row  = row;
		r.dot  = dot;
		r.st   = st;
		r.last = last;
		return r;
	endfunction

	function automatic mvm_item_t make_item(input logic act, input int row, input int col,
			input logic [VALUE_IN_W-1:0] val, input logic last);
		mvm_item_t it;
		it.act  = act;
		it.row  = ROW_IDX_W'(row);
		it.col  = COL_IDX_W'(col);
		it.val  = val;
		it.last = last;
		return it;
	endfunction

	function automatic logic [VALUE_IN_W-1:0] pick_value();
		logic [VALUE_IN_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7fff;
			2: v = VALUE_IN_W'($urandom_range(0, 15)) - 16'd8;
			default: v = VALUE_IN_W'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	function automatic mvm_item_t vec_item(input logic last);
		return make_item(ACT_VECTOR, $urandom_range(0, 15), $urandom_range(0, 15),
			pick_value(), last);
	endfunction

	function automatic mvm_item_t noise_write();
		return make_item(ACT_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
			pick_value(), 1'($urandom_range(0, 1)));
	endfunction

	function automatic int clamp_dim_raw(input logic [4:0] raw);
		if (raw == 5'd0) begin
			return 1;
		end
		if (int'(raw) > DEF_MAX_ROWS) begin
			return DEF_MAX_ROWS;
		end
		return int'(raw);
	endfunction

	// works out the transactions one accepted input causes
	function automatic void multiply_step(input mvm_item_t it);
		longint acc;
		step_out.delete();
		if (it.act == ACT_WRITE) begin
			if (int'(it.row) >= n_rows || int'(it.col) >= n_cols) begin
				step_out.push_back(make_res(it.row, '0, ST_RANGE, 1'b0));
			end else begin
				coef[it.row][it.col] = it.val;
				coef_set[it.row][it.col] = 1'b1;
				step_out.push_back(make_res(it.row, '0, ST_OK, 1'b0));
			end
			return;
		end
		if (vec_cnt < n_cols) begin
			vec_buf[vec_cnt] = it.val;
			vec_cnt++;
		end else begin
			vec_over = 1'b1;
		end
		if (!it.last) begin
			return;
		end
		if (vec_over || vec_cnt != n_cols) begin
			step_out.push_back(make_res('0, '0, ST_MISMATCH, 1'b1));
		end else begin
			for (int r = 0; r < n_rows; r++) begin
				acc = 0;
				for (int c = 0; c < n_cols; c++) begin
					acc += longint'(coef[r][c]) * longint'(vec_buf[c]);
					if (acc > DOT_HI) acc = DOT_HI;
					if (acc < DOT_LO) acc = DOT_LO;
				end
				step_out.push_back(make_res(ROW_IDX_W'(r), acc[DOT_W-1:0], ST_OK,
					r == n_rows - 1));
			end
		end
		vec_cnt = 0;
		vec_over = 1'b0;
	endfunction

	function automatic void flag_error(input string msg);
		bad_count++;
		if (bad_count <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	function automatic void tab_cfg(input logic reg_idx, input logic [4:0] raw);
		step_t s;
		s = '0;
		s.kind = STEP_CFG;
		s.reg_idx = reg_idx;
		s.raw = raw;
		directed_tab.push_back(s);
	endfunction

	function automatic void tab_item(input mvm_item_t it);
		step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.it = it;
		directed_tab.push_back(s);
	endfunction

	function automatic void tab_check(input mvm_item_t it, input mvm_res_t want);
		step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.it = it;
		s.typed = 1'b1;
		s.want = want;
		directed_tab.push_back(s);
	endfunction

	task automatic offer(input mvm_item_t it, input logic typed, input mvm_res_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid  <= 1'b1;
		action    <= it.act;
		row_sel   <= it.row;
		col_sel   <= it.col;
		value     <= it.val;
		last_elem <= it.last;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sent++;
		multiply_step(it);
		if (typed) begin
			row_results_q.push_back(want);
		end else begin
			foreach (step_out[k]) row_results_q.push_back(step_out[k]);
		end
	endtask

	// register write, only once the block has gone quiet
	task automatic set_dim(input logic reg_idx, input logic [4:0] raw);
		logic [APB_DW-1:0] pw;
		@(negedge clk);
		in_valid <= 1'b0;
		while (row_results_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		pw = $urandom();
		pw[4:0] = raw;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= pw;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_ROWS) begin
			n_rows = clamp_dim_raw(raw);
		end else begin
			n_cols = clamp_dim_raw(raw);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1000000);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		int mode;
		int mode_left;
		bit hold_taken;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		hold_taken = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_left = 300;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : result_checker
		mvm_res_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (row_results_q.size() == 0) begin
					flag_error($sformatf("unexpected transaction row %0d dot %0d status %0d last %0b",
						row_index, dot_product, status, last_result));
				end else begin
					e = row_results_q.pop_front();
					if (row_index !== e.row || dot_product !== e.dot || status !== e.st ||
							last_result !== e.last) begin
						flag_error($sformatf({"mismatch: exp row %0d dot %0d status %0d last %0b,",
							" got row %0d dot %0d status %0d last %0b"}, e.row, e.dot, e.st,
							e.last, row_index, dot_product, status, last_result));
					end
				end
			end
		end
	end

	initial begin : stimulus
		int pick;
		int units;
		int len;
		int phase;
		logic [4:0] rows_raw;
		logic [4:0] cols_raw;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		action    = ACT_WRITE;
		row_sel   = '0;
		col_sel   = '0;
		value     = '0;
		last_elem = 1'b0;
		foreach (coef_set[r, c]) coef_set[r][c] = 1'b0;

		// reset dimensions, nothing loaded yet
		tab_check(make_item(ACT_VECTOR, 3, 9, 16'h7fff, 1'b1),
			make_res(0, 0, ST_MISMATCH, 1'b1));
		// zero saturates up to one
		tab_cfg(REG_ROWS, 5'd0);
		tab_cfg(REG_COLS, 5'd0);
		tab_check(make_item(ACT_WRITE, 1, 0, 16'h1234, 1'b0), make_res(1, 0, ST_RANGE, 1'b0));
		tab_check(make_item(ACT_WRITE, 0, 1, 16'h4321, 1'b1), make_res(0, 0, ST_RANGE, 1'b0));
		tab_check(make_item(ACT_WRITE, 0, 0, 16'h8000, 1'b0), make_res(0, 0, ST_OK, 1'b0));
		tab_check(make_item(ACT_VECTOR, 0, 0, 16'h8000, 1'b1),
			make_res(0, 40'sd1073741824, ST_OK, 1'b1));
		// one element too many
		tab_item(make_item(ACT_VECTOR, 15, 15, 16'h0001, 1'b0));
		tab_check(make_item(ACT_VECTOR, 0, 0, 16'h0002, 1'b1),
			make_res(0, 0, ST_MISMATCH, 1'b1));
		tab_cfg(REG_ROWS, 5'd2);
		tab_cfg(REG_COLS, 5'd2);
		tab_check(make_item(ACT_WRITE, 2, 0, 16'h0100, 1'b0), make_res(2, 0, ST_RANGE, 1'b0));
		tab_check(make_item(ACT_WRITE, 15, 15, 16'hffff, 1'b1),
			make_res(15, 0, ST_RANGE, 1'b0));
		tab_check(make_item(ACT_WRITE, 0, 0, 16'h7fff, 1'b0), make_res(0, 0, ST_OK, 1'b0));
		tab_item(make_item(ACT_WRITE, 0, 1, 16'h8000, 1'b0));
		tab_item(make_item(ACT_WRITE, 1, 0, 16'hffff, 1'b0));
		tab_check(make_item(ACT_WRITE, 1, 1, 16'h0001, 1'b0), make_res(1, 0, ST_OK, 1'b0));
		// run ended early
		tab_check(make_item(ACT_VECTOR, 0, 0, 16'h1234, 1'b1),
			make_res(0, 0, ST_MISMATCH, 1'b1));
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h8000, 1'b0));
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h7fff, 1'b1));
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h0003, 1'b0));
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h0004, 1'b0));
		tab_check(make_item(ACT_VECTOR, 0, 0, 16'h0005, 1'b1),
			make_res(0, 0, ST_MISMATCH, 1'b1));
		// column count changed in the middle of a run
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h0100, 1'b0));
		tab_cfg(REG_COLS, 5'd1);
		tab_check(make_item(ACT_VECTOR, 0, 0, 16'h0200, 1'b1),
			make_res(0, 0, ST_MISMATCH, 1'b1));
		tab_item(make_item(ACT_VECTOR, 0, 0, 16'h8001, 1'b1));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_tab[i]) begin
			if (directed_tab[i].kind == STEP_CFG) begin
				set_dim(directed_tab[i].reg_idx, directed_tab[i].raw);
			end else begin
				offer(directed_tab[i].it, directed_tab[i].typed, directed_tab[i].want);
			end
		end

		phase = 0;
		while (sent < 230) begin
			case (phase)
				1: begin
					rows_raw = 5'd20;
					cols_raw = 5'd3;
				end
				2: begin
					rows_raw = 5'd0;
					cols_raw = 5'd31;
				end
				default: begin
					pick = $urandom_range(0, 9);
					rows_raw = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(17, 31)) :
						5'($urandom_range(1, 4));
					pick = $urandom_range(0, 9);
					cols_raw = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(16, 31)) :
						5'($urandom_range(1, 5));
				end
			endcase
			set_dim(REG_ROWS, rows_raw);
			set_dim(REG_COLS, cols_raw);
			if (phase == 0) begin
				hold_request = 1'b1;
			end
			// every entry in use gets loaded before any run can read it
			for (int r = 0; r < n_rows; r++) begin
				for (int c = 0; c < n_cols; c++) begin
					if (!coef_set[r][c]) begin
						offer(make_item(ACT_WRITE, r, c, pick_value(),
							1'($urandom_range(0, 1))), 1'b0, '0);
					end
				end
			end
			units = (n_cols > 8) ? $urandom_range(4, 8) : $urandom_range(6, 14);
			repeat (units) begin
				if (sent >= 230) break;
				pick = $urandom_range(0, 19);
				if (pick < 13) begin
					for (int k = 0; k < n_cols; k++) begin
						if ($urandom_range(0, 15) == 0) begin
							offer(noise_write(), 1'b0, '0);
						end
						offer(vec_item(k == n_cols - 1), 1'b0, '0);
					end
				end else if (pick < 17) begin
					len = $urandom_range(1, n_cols + 2);
					for (int k = 0; k < len; k++) begin
						offer(vec_item(k == len - 1), 1'b0, '0);
					end
				end else begin
					offer(noise_write(), 1'b0, '0);
				end
			end
			phase++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (row_results_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (bad_count == 0 && row_results_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_store.sv
hw/rtl/mvm_mac.sv
hw/rtl/matrix_vector_multiply.sv
hw/rtl/mvm_checker.sv
sim/matrix_vector_multiply_tb.sv
